// ===== rtl/mhsic_pkg.sv =====
// ----------------------------------------------------------------------------
// mhsic_pkg
// Shared constants, widths and types of the magnetometer iron-correction core.
// ----------------------------------------------------------------------------
package mhsic_pkg;

  // Sample and ratio formats
  localparam int SAMPLE_BITS     = 16;
  localparam int RATIO_FRAC_BITS = 12;
  localparam int NUM_AXES        = 3;

  // Fixed field widths
  localparam int SCALE_W    = 16;
  localparam int SCALE_FRAC = 14;
  localparam int EARTH_W    = 15;
  localparam int RATIO_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_W      = (SAMPLE_BITS > SCALE_W) ? SAMPLE_BITS : SCALE_W;

  // Derived datapath widths
  localparam int PROD_W = SAMPLE_BITS + 1 + SCALE_W;   // (raw - offset) * scale
  localparam int SHR_W  = PROD_W - SCALE_FRAC;          // product after the Q2.14 shift
  localparam int SQ_W   = 2 * SAMPLE_BITS - 1;          // square of one saturated axis
  localparam int SUM_W  = 2 * SAMPLE_BITS;              // sum of three squares
  localparam int NUM_W  = SAMPLE_BITS + RATIO_FRAC_BITS; // magnitude scaled for the ratio

  // Smoothing: floor((99 * old + new) / 100), division by reciprocal multiply
  localparam int              SMOOTH_OLD   = 99;
  localparam int              ACC_W        = RATIO_W + 7;
  localparam int              RECIP_W      = 24;
  localparam int              SMOOTH_SHIFT = 30;
  localparam logic [RECIP_W-1:0] SMOOTH_RECIP = 24'd10737419;  // ceil(2^30 / 100)
  localparam int              MULT_W       = ACC_W + RECIP_W;

  // Reset values of the registers
  localparam logic [SAMPLE_BITS-1:0] OFFSET_RST = '0;
  localparam logic [SCALE_W-1:0]     SCALE_RST  = 16'd16384;
  localparam logic [EARTH_W-1:0]     EARTH_RST  = 15'd436;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET_X    = 3'd0,
    CFG_OFFSET_Y    = 3'd1,
    CFG_OFFSET_Z    = 3'd2,
    CFG_SCALE_X     = 3'd3,
    CFG_SCALE_Y     = 3'd4,
    CFG_SCALE_Z     = 3'd5,
    CFG_EARTH_FIELD = 3'd6
  } cfg_idx_e;

  // What one axis lane hands to the merge unit
  typedef struct packed {
    logic                   vld;
    logic [SAMPLE_BITS-1:0] cal;
    logic [SQ_W-1:0]        sq;
  } lane_res_t;

  // What the merge unit hands to the output stage
  typedef struct packed {
    logic               vld;
    logic [RATIO_W-1:0] ratio;
  } merge_res_t;

endpackage

// ===== rtl/mhsic_if.sv =====
// ----------------------------------------------------------------------------
// mhsic_in_if / mhsic_out_if
// Valid/ready channels for raw samples and corrected results.
// ----------------------------------------------------------------------------
interface mhsic_in_if import mhsic_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] raw_x;
  logic signed [SAMPLE_BITS-1:0] raw_y;
  logic signed [SAMPLE_BITS-1:0] raw_z;

  modport source (output valid, raw_x, raw_y, raw_z, input ready);
  modport sink   (input valid, raw_x, raw_y, raw_z, output ready);
endinterface

interface mhsic_out_if import mhsic_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] cal_x;
  logic signed [SAMPLE_BITS-1:0] cal_y;
  logic signed [SAMPLE_BITS-1:0] cal_z;
  logic        [RATIO_W-1:0]     field_ratio;

  modport source (output valid, cal_x, cal_y, cal_z, field_ratio, input ready);
  modport sink   (input valid, cal_x, cal_y, cal_z, field_ratio, output ready);
endinterface

// ===== rtl/mhsic_lane.sv =====
// ----------------------------------------------------------------------------
// mhsic_lane
// One axis: subtract the hard-iron offset, apply the Q2.14 scale with floor
// rounding and saturation, then square the corrected value.
// ----------------------------------------------------------------------------
module mhsic_lane import mhsic_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [SAMPLE_BITS-1:0] raw_i,
  input  logic [SAMPLE_BITS-1:0] offset_i,
  input  logic [SCALE_W-1:0]     scale_i,
  output lane_res_t              res_o
);

  logic signed [SAMPLE_BITS:0]   diff_w;
  logic signed [PROD_W-1:0]      prod_d, prod_q;
  logic signed [SHR_W-1:0]       shr_w;
  logic                          ovf_w;
  logic [SAMPLE_BITS-1:0]        cal_d, cal_q;
  logic signed [SUM_W-1:0]       sq_full_w;
  logic [SQ_W-1:0]               sq_q;
  logic                          v1_q, v2_q, v3_q;

  // Offset removal and scale multiply, both exact
  assign diff_w = $signed({raw_i[SAMPLE_BITS-1], raw_i})
                - $signed({offset_i[SAMPLE_BITS-1], offset_i});
  assign prod_d = PROD_W'(diff_w) * PROD_W'($signed({1'b0, scale_i}));

  // Floor shift, then clamp when the upper bits are not a plain sign extension
  assign shr_w = SHR_W'(prod_q >>> SCALE_FRAC);
  assign ovf_w = (shr_w[SHR_W-1:SAMPLE_BITS-1] != {(SHR_W-SAMPLE_BITS+1){1'b0}})
              && (shr_w[SHR_W-1:SAMPLE_BITS-1] != {(SHR_W-SAMPLE_BITS+1){1'b1}});

  always_comb begin
    if (!ovf_w) begin
      cal_d = shr_w[SAMPLE_BITS-1:0];
    end else if (shr_w[SHR_W-1]) begin
      cal_d = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      cal_d = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  // Square of the saturated axis, never negative
  assign sq_full_w = SUM_W'($signed(cal_q)) * SUM_W'($signed(cal_q));

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Stage data; cal holds until the next sample starts
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q <= prod_d;
    end
    if (v1_q) begin
      cal_q <= cal_d;
    end
    if (v2_q) begin
      sq_q <= sq_full_w[SQ_W-1:0];
    end
  end

  assign res_o.vld = v3_q;
  assign res_o.cal = cal_q;
  assign res_o.sq  = sq_q;

endmodule

// ===== rtl/mhsic_merge.sv =====
// ----------------------------------------------------------------------------
// mhsic_merge
// Combine the lanes: sum of squares, bit-serial square root, radix-4 ratio
// divider against the earth field, and the 99/100 smoothing filter.
// ----------------------------------------------------------------------------
module mhsic_merge import mhsic_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lane_res_t          lanes_i [NUM_AXES],
  input  logic [EARTH_W-1:0] earth_i,
  input  logic               res_ready_i,
  output merge_res_t         res_o
);

  localparam int CNT_W     = $clog2(SAMPLE_BITS);
  localparam int DIV_STEPS = RATIO_W / 2;
  localparam int CMP_W     = SAMPLE_BITS + EARTH_W + RATIO_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQRT,
    S_RATIO,
    S_DIV,
    S_BLEND,
    S_SCALE,
    S_WRITE,
    S_DONE
  } state_e;

  state_e                 state_q;
  logic [CNT_W-1:0]       cnt_q;
  logic [RATIO_W-1:0]     smooth_q;

  logic                   lanes_vld_w;
  logic [SUM_W-1:0]       sum_w, sum_q;
  logic [SAMPLE_BITS+1:0] rem_sh_w, trial_w, srem_d, srem_q;
  logic                   sq_ge_w;
  logic [SAMPLE_BITS-1:0] root_d, root_q;
  logic [NUM_W-1:0]       num_w;
  logic                   sat_w;
  logic [EARTH_W-1:0]     drem_d, drem_q;
  logic [RATIO_W-1:0]     dlo_d, dlo_q;
  logic [EARTH_W:0]       dsh_w [2];
  logic                   dge_w [2];
  logic [ACC_W-1:0]       acc_q;
  logic [MULT_W-1:0]      mult_q;

  assign lanes_vld_w = lanes_i[0].vld & lanes_i[1].vld & lanes_i[2].vld;
  assign sum_w = SUM_W'(lanes_i[0].sq) + SUM_W'(lanes_i[1].sq) + SUM_W'(lanes_i[2].sq);

  // One root bit per step: bring down two radicand bits, try 4*root + 1
  assign rem_sh_w = {srem_q[SAMPLE_BITS-1:0], sum_q[SUM_W-1 -: 2]};
  assign trial_w  = {root_q, 2'b01};
  assign sq_ge_w  = rem_sh_w >= trial_w;
  assign srem_d   = sq_ge_w ? rem_sh_w - trial_w : rem_sh_w;
  assign root_d   = {root_q[SAMPLE_BITS-2:0], sq_ge_w};

  // Ratio saturates when the quotient would need more than RATIO_W bits
  assign num_w = {root_q, {RATIO_FRAC_BITS{1'b0}}};
  assign sat_w = CMP_W'(root_q) >= (CMP_W'(earth_i) << (RATIO_W - RATIO_FRAC_BITS));

  // Two restoring divide steps; quotient bits shift in as dividend bits leave
  always_comb begin
    dsh_w[0] = {drem_q, dlo_q[RATIO_W-1]};
    dge_w[0] = dsh_w[0] >= {1'b0, earth_i};
    dsh_w[1] = {(dge_w[0] ? EARTH_W'(dsh_w[0] - {1'b0, earth_i}) : EARTH_W'(dsh_w[0])),
                dlo_q[RATIO_W-2]};
    dge_w[1] = dsh_w[1] >= {1'b0, earth_i};
    drem_d   = dge_w[1] ? EARTH_W'(dsh_w[1] - {1'b0, earth_i}) : EARTH_W'(dsh_w[1]);
    dlo_d    = {dlo_q[RATIO_W-3:0], dge_w[0], dge_w[1]};
  end

  // Sequencer and kept filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      smooth_q <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          cnt_q <= '0;
          if (lanes_vld_w) begin
            state_q <= S_SQRT;
          end
        end
        S_SQRT: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(SAMPLE_BITS - 1)) begin
            state_q <= S_RATIO;
          end
        end
        S_RATIO: begin
          cnt_q   <= '0;
          state_q <= sat_w ? S_BLEND : S_DIV;
        end
        S_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
            state_q <= S_BLEND;
          end
        end
        S_BLEND: begin
          state_q <= S_SCALE;
        end
        S_SCALE: begin
          state_q <= S_WRITE;
        end
        S_WRITE: begin
          smooth_q <= mult_q[SMOOTH_SHIFT +: RATIO_W];
          state_q  <= S_DONE;
        end
        S_DONE: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (lanes_vld_w) begin
          sum_q  <= sum_w;
          srem_q <= '0;
          root_q <= '0;
        end
      end
      S_SQRT: begin
        sum_q  <= sum_q << 2;
        srem_q <= srem_d;
        root_q <= root_d;
      end
      S_RATIO: begin
        if (sat_w) begin
          dlo_q <= '1;
        end else begin
          drem_q <= EARTH_W'(num_w >> RATIO_W);
          dlo_q  <= num_w[RATIO_W-1:0];
        end
      end
      S_DIV: begin
        drem_q <= drem_d;
        dlo_q  <= dlo_d;
      end
      S_BLEND: begin
        acc_q <= ACC_W'(smooth_q) * ACC_W'(SMOOTH_OLD) + ACC_W'(dlo_q);
      end
      S_SCALE: begin
        mult_q <= MULT_W'(acc_q) * MULT_W'(SMOOTH_RECIP);
      end
      default: begin
      end
    endcase
  end

  assign res_o.vld   = (state_q == S_DONE);
  assign res_o.ratio = smooth_q;

endmodule

// ===== rtl/magnetometer_hard_soft_iron_correct_core.sv =====
// ----------------------------------------------------------------------------
// magnetometer_hard_soft_iron_correct_core
// Hard/soft-iron correction of three-axis samples with a smoothed
// field-strength ratio as an interference indicator.
// ----------------------------------------------------------------------------
// Usage:
//   in_i   : one raw sample (raw_x/y/z) per transfer, valid/ready.
//   out_o  : one result per sample (cal_x/y/z, field_ratio), valid/ready.
//   cfg_*  : register writes by index, taken at any edge with cfg_we_i high;
//            write only while no sample is in flight.
//   Three axis lanes correct and square in parallel; one merge unit sums,
//   takes the root (16 steps), divides by the earth field (8 two-bit steps)
//   and runs the 99/100 filter, skipping the divider when the ratio saturates.
//   A new sample is taken only once the previous result has reached the
//   output register; the root and divider of the merge unit pace the intake.
//   A finished result waits in the output register while the next sample is
//   already being processed; if the receiver stalls longer, the next result
//   holds in the merge unit and in_i stays not ready.
//   Reset clears the filter state to zero and loads the register defaults
//   (offsets 0, scales 1.0, earth field 436).
// ----------------------------------------------------------------------------
module magnetometer_hard_soft_iron_correct_core import mhsic_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  mhsic_in_if.sink             in_i,
  mhsic_out_if.source          out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  logic [SAMPLE_BITS-1:0] offset_q [NUM_AXES];
  logic [SCALE_W-1:0]     scale_q  [NUM_AXES];
  logic [EARTH_W-1:0]     earth_q;

  logic                   busy_q;
  logic                   in_xfer_w;
  logic [SAMPLE_BITS-1:0] raw_w [NUM_AXES];
  lane_res_t              lane_res_w [NUM_AXES];
  merge_res_t             merge_res_w;
  logic                   res_ready_w;
  logic                   res_xfer_w;

  logic                   out_vld_q;
  logic [SAMPLE_BITS-1:0] cal_q [NUM_AXES];
  logic [RATIO_W-1:0]     ratio_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        offset_q[a] <= OFFSET_RST;
        scale_q[a]  <= SCALE_RST;
      end
      earth_q <= EARTH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_OFFSET_X:    offset_q[0] <= cfg_data_i[SAMPLE_BITS-1:0];
        CFG_OFFSET_Y:    offset_q[1] <= cfg_data_i[SAMPLE_BITS-1:0];
        CFG_OFFSET_Z:    offset_q[2] <= cfg_data_i[SAMPLE_BITS-1:0];
        CFG_SCALE_X:     scale_q[0]  <= cfg_data_i[SCALE_W-1:0];
        CFG_SCALE_Y:     scale_q[1]  <= cfg_data_i[SCALE_W-1:0];
        CFG_SCALE_Z:     scale_q[2]  <= cfg_data_i[SCALE_W-1:0];
        CFG_EARTH_FIELD: earth_q     <= cfg_data_i[EARTH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input side: one sample in flight until its result reaches the output register
  assign in_i.ready = !busy_q;
  assign in_xfer_w  = in_i.valid && !busy_q;

  assign raw_w[0] = in_i.raw_x;
  assign raw_w[1] = in_i.raw_y;
  assign raw_w[2] = in_i.raw_z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (in_xfer_w) begin
      busy_q <= 1'b1;
    end else if (res_xfer_w) begin
      busy_q <= 1'b0;
    end
  end

  // Axis lanes
  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    mhsic_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .start_i  (in_xfer_w),
      .raw_i    (raw_w[a]),
      .offset_i (offset_q[a]),
      .scale_i  (scale_q[a]),
      .res_o    (lane_res_w[a])
    );
  end

  // Magnitude, ratio and filter
  mhsic_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .lanes_i     (lane_res_w),
    .earth_i     (earth_q),
    .res_ready_i (res_ready_w),
    .res_o       (merge_res_w)
  );

  // Output register: load when empty or being drained
  assign res_ready_w = !out_vld_q || out_o.ready;
  assign res_xfer_w  = merge_res_w.vld && res_ready_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_ready_w) begin
      out_vld_q <= merge_res_w.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_xfer_w) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        cal_q[a] <= lane_res_w[a].cal;
      end
      ratio_q <= merge_res_w.ratio;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.cal_x       = cal_q[0];
  assign out_o.cal_y       = cal_q[1];
  assign out_o.cal_z       = cal_q[2];
  assign out_o.field_ratio = ratio_q;

  // Lane results only appear for a sample in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    lane_res_w[0].vld |-> busy_q)
    else $error("lane result without a sample in flight");

  // The merge unit never offers a result while idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> !merge_res_w.vld)
    else $error("merge result while no sample is in flight");

  // An accepted sample blocks further input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer_w |=> !in_i.ready)
    else $error("input still ready after a sample transfer");

  // A handed-over result lands in the output register and frees the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_xfer_w |=> (out_o.valid && in_i.ready))
    else $error("result handoff did not load output or free input");

endmodule

// ===== tb/sv/magnetometer_hard_soft_iron_correct_core_tb.sv =====
// ----------------------------------------------------------------------------
// magnetometer_hard_soft_iron_correct_core_tb
// Self-checking bench for the iron-correction core. Raw three-axis samples
// are streamed over valid/ready with random gaps and output stalls. A
// fixed-point predictor mirrors per-axis offset/scale correction, the
// magnitude root, the earth-field ratio and the 99/100 filter, and every
// result is compared field by field in order. Register settings change
// between phases while the core is drained, including the extreme ones.
// ----------------------------------------------------------------------------
module magnetometer_hard_soft_iron_correct_core_tb import mhsic_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;  // no register behind it
  localparam longint RATIO_CAP  = (64'd1 << RATIO_W) - 1;
  localparam longint SMOOTH_DEN = 100;
  localparam longint AXIS_HI    = (64'd1 << (SAMPLE_BITS - 1)) - 1;
  localparam longint AXIS_LO    = -AXIS_HI - 1;
  localparam int     DRAIN_CYCLES = 40;
  localparam int     QUIET_FROM   = 15000;
  localparam int     QUIET_TO     = 27000;
  localparam int     RAND_PHASES  = 6;
  localparam int     PHASE_ITEMS  = 325;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] x;
    logic signed [SAMPLE_BITS-1:0] y;
    logic signed [SAMPLE_BITS-1:0] z;
  } sample_t;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] x;
    logic signed [SAMPLE_BITS-1:0] y;
    logic signed [SAMPLE_BITS-1:0] z;
    logic        [RATIO_W-1:0]     ratio;
  } corrected_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  mhsic_in_if  in_if ();
  mhsic_out_if out_if ();

  magnetometer_hard_soft_iron_correct_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Predictor copy of registers and filter state
  logic signed [SAMPLE_BITS-1:0] iron_offset [NUM_AXES];
  logic        [SCALE_W-1:0]     iron_scale  [NUM_AXES];
  logic        [EARTH_W-1:0]     earth_cnt;
  logic        [RATIO_W-1:0]     ratio_avg;

  sample_t    raw_pending_q [$];
  corrected_t corrected_q   [$];
  int         fail_cnt;
  int         cycle_cnt;

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // Random pause of about one cycle in ten, none inside the quiet window
  function automatic bit idle_roll();
    if (cycle_cnt >= QUIET_FROM && cycle_cnt < QUIET_TO) begin
      return 1'b0;
    end
    return $urandom_range(0, 99) < 10;
  endfunction

  // Offset, Q2.14 scale with floor, saturate to the sample range
  function automatic logic signed [SAMPLE_BITS-1:0] correct_axis(
    logic signed [SAMPLE_BITS-1:0] raw, logic signed [SAMPLE_BITS-1:0] off,
    logic [SCALE_W-1:0] scl);
    longint prod;
    longint quo;
    prod = (longint'(raw) - longint'(off)) * longint'(scl);
    quo  = prod >>> SCALE_FRAC;
    if (quo > AXIS_HI) quo = AXIS_HI;
    if (quo < AXIS_LO) quo = AXIS_LO;
    return quo[SAMPLE_BITS-1:0];
  endfunction

  // Truncated integer square root, one result bit per step
  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned root;
    longint unsigned cand;
    root = 0;
    for (int b = 17; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if (cand * cand <= v) root = cand;
    end
    return root;
  endfunction

  // Expected result of one sample; advances the filter state
  function automatic corrected_t iron_correct(sample_t s);
    corrected_t r;
    longint unsigned sq_sum;
    longint unsigned mag;
    longint unsigned quot;
    r.x = correct_axis(s.x, iron_offset[0], iron_scale[0]);
    r.y = correct_axis(s.y, iron_offset[1], iron_scale[1]);
    r.z = correct_axis(s.z, iron_offset[2], iron_scale[2]);
    sq_sum = longint'(r.x) * longint'(r.x) + longint'(r.y) * longint'(r.y)
           + longint'(r.z) * longint'(r.z);
    mag = floor_root(sq_sum);
    if (earth_cnt == 0) begin
      quot = RATIO_CAP;
    end else begin
      quot = (mag << RATIO_FRAC_BITS) / longint'(earth_cnt);
      if (quot > RATIO_CAP) quot = RATIO_CAP;
    end
    ratio_avg = RATIO_W'((longint'(ratio_avg) * SMOOTH_OLD + quot) / SMOOTH_DEN);
    r.ratio = ratio_avg;
    return r;
  endfunction

  function automatic void check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_cnt++;
    end
  endfunction

  // Sample driver: hold until transfer, then advance to the next pending sample
  always @(posedge clk_i) begin
    sample_t taken;
    sample_t nxt;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        taken.x = in_if.raw_x;
        taken.y = in_if.raw_y;
        taken.z = in_if.raw_z;
        corrected_q.push_back(iron_correct(taken));
      end
      if (!in_if.valid || in_if.ready) begin
        if (raw_pending_q.size() != 0 && !idle_roll()) begin
          nxt = raw_pending_q.pop_front();
          in_if.valid <= 1'b1;
          in_if.raw_x <= nxt.x;
          in_if.raw_y <= nxt.y;
          in_if.raw_z <= nxt.z;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each transfer with the oldest expectation
  always @(posedge clk_i) begin
    corrected_t want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (corrected_q.size() == 0) begin
          $error("unexpected result: cal_x %0d cal_y %0d cal_z %0d field_ratio %0d",
                 out_if.cal_x, out_if.cal_y, out_if.cal_z, out_if.field_ratio);
          fail_cnt++;
        end else begin
          want = corrected_q.pop_front();
          check_field("cal_x", want.x, out_if.cal_x);
          check_field("cal_y", want.y, out_if.cal_y);
          check_field("cal_z", want.z, out_if.cal_z);
          check_field("field_ratio", want.ratio, out_if.field_ratio);
        end
      end
      out_if.ready <= !idle_roll();
    end
  end

  function automatic void push_raw(int x, int y, int z);
    sample_t s;
    s.x = SAMPLE_BITS'(x);
    s.y = SAMPLE_BITS'(y);
    s.z = SAMPLE_BITS'(z);
    raw_pending_q.push_back(s);
  endfunction

  // Wait until nothing is pending, in flight or expected
  task automatic settle();
    @(posedge clk_i);
    while (raw_pending_q.size() != 0 || in_if.valid || corrected_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // One register write; call at a rising edge with the core drained
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    case (idx)
      CFG_OFFSET_X:    iron_offset[0] = value[SAMPLE_BITS-1:0];
      CFG_OFFSET_Y:    iron_offset[1] = value[SAMPLE_BITS-1:0];
      CFG_OFFSET_Z:    iron_offset[2] = value[SAMPLE_BITS-1:0];
      CFG_SCALE_X:     iron_scale[0]  = value[SCALE_W-1:0];
      CFG_SCALE_Y:     iron_scale[1]  = value[SCALE_W-1:0];
      CFG_SCALE_Z:     iron_scale[2]  = value[SCALE_W-1:0];
      CFG_EARTH_FIELD: earth_cnt      = value[EARTH_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic load_setup(logic [CFG_W-1:0] ox, logic [CFG_W-1:0] oy,
                            logic [CFG_W-1:0] oz, logic [CFG_W-1:0] sx,
                            logic [CFG_W-1:0] sy, logic [CFG_W-1:0] sz,
                            logic [CFG_W-1:0] earth);
    write_reg(CFG_OFFSET_X, ox);
    write_reg(CFG_OFFSET_Y, oy);
    write_reg(CFG_OFFSET_Z, oz);
    write_reg(CFG_SCALE_X, sx);
    write_reg(CFG_SCALE_Y, sy);
    write_reg(CFG_SCALE_Z, sz);
    write_reg(CFG_EARTH_FIELD, earth);
    if ($urandom_range(0, 1)) begin
      write_reg(CFG_SPARE, CFG_W'($urandom));
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic int pick_extreme();
    case ($urandom_range(0, 3))
      0:       return int'(AXIS_LO);
      1:       return int'(AXIS_HI);
      2:       return 0;
      default: return -1;
    endcase
  endfunction

  // Mostly samples near the hard-iron center, plus full-range and extremes
  function automatic void push_random_raw();
    int sel;
    int span;
    sel  = $urandom_range(0, 9);
    span = (sel == 9) ? 8 : 4000;
    if (sel <= 5 || sel == 9) begin
      push_raw(int'(iron_offset[0]) + $urandom_range(0, 2 * span) - span,
               int'(iron_offset[1]) + $urandom_range(0, 2 * span) - span,
               int'(iron_offset[2]) + $urandom_range(0, 2 * span) - span);
    end else if (sel <= 7) begin
      push_raw($urandom, $urandom, $urandom);
    end else begin
      push_raw(pick_extreme(), pick_extreme(), pick_extreme());
    end
  endfunction

  // Stimulus and end of run
  initial begin
    iron_offset = '{OFFSET_RST, OFFSET_RST, OFFSET_RST};
    iron_scale  = '{SCALE_RST, SCALE_RST, SCALE_RST};
    earth_cnt   = EARTH_RST;
    ratio_avg   = '0;
    fail_cnt    = 0;
    cycle_cnt   = 0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_OFFSET_X;
    cfg_data_i  = '0;
    in_if.valid = 1'b0;
    in_if.raw_x = '0;
    in_if.raw_y = '0;
    in_if.raw_z = '0;
    out_if.ready = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Default registers: zero, full-scale corners, sign and floor behavior
    push_raw(0, 0, 0);
    push_raw(32767, 32767, 32767);
    push_raw(-32768, -32768, -32768);
    push_raw(32767, -32768, 0);
    push_raw(1, -1, -2);
    push_raw(436, 0, 0);
    push_raw(-436, 300, 200);
    settle();

    // Scale above 2.0, most negative offsets, zero earth field
    load_setup(16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
    push_raw(32767, 32767, 32767);
    push_raw(-32768, -32768, -32768);
    push_raw(0, 0, 0);
    push_raw(-32767, 1, 2);
    settle();

    // Zero scale, most positive offsets, largest earth field, spare index
    load_setup(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF);
    write_reg(CFG_SPARE, 16'hFFFF);
    cfg_we_i <= 1'b0;
    push_raw(-32768, -32768, -32768);
    push_raw(32767, 32767, 32767);
    settle();

    // Scale exactly 2.0 and earth field of one count
    load_setup(16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h8000, 16'h8000, 16'h0001);
    push_raw(1, 1, 1);
    push_raw(-1, -1, -1);
    push_raw(16383, -16384, 5);
    settle();

    // Random phases: plausible calibrations alternate with arbitrary patterns;
    // drain fully between phases before touching the registers
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph % 2 == 0) begin
        load_setup(CFG_W'($urandom_range(0, 6000) - 3000),
                   CFG_W'($urandom_range(0, 6000) - 3000),
                   CFG_W'($urandom_range(0, 6000) - 3000),
                   CFG_W'($urandom_range(12000, 24000)),
                   CFG_W'($urandom_range(12000, 24000)),
                   CFG_W'($urandom_range(12000, 24000)),
                   CFG_W'($urandom_range(200, 3000)));
      end else begin
        load_setup(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                   CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                   CFG_W'($urandom));
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        push_random_raw();
      end
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
